### hdl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types, widths and codes of the scanline triangle rasterizer.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;

  localparam int COORD_W = 12;
  localparam int ROW_W   = 9;
  localparam int COL_W   = 10;
  localparam int FIX_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int COLOR_W = 16;
  localparam int ADDR_W  = 32;

  // slope dividend is |dx| << FRAC_W, one quotient bit per divider step
  localparam int DIV_W     = COORD_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] vert_a_x;
    logic signed [COORD_W-1:0] vert_a_y;
    logic signed [COORD_W-1:0] vert_b_x;
    logic signed [COORD_W-1:0] vert_b_y;
    logic signed [COORD_W-1:0] vert_c_x;
    logic signed [COORD_W-1:0] vert_c_y;
    logic [COLOR_W-1:0]        fill_color;
  } tsr_in_t;

  typedef struct packed {
    logic               span_valid;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   left_x;
    logic [COL_W-1:0]   right_x;
    logic [COL_W-1:0]   pixel_count;
    logic [ADDR_W-1:0]  start_address;
    logic [COLOR_W-1:0] span_color;
    logic               last;
  } tsr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT,
    ST_PREP,
    ST_DIV_LONG,
    ST_WAIT_LONG,
    ST_DIV_UPPER,
    ST_WAIT_UPPER,
    ST_DIV_LOWER,
    ST_WAIT_LOWER,
    ST_MUL_LONG,
    ST_MUL_LOWER,
    ST_MUL_UPPER,
    ST_ARM
  } tsr_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SORT,
    OP_PREP,
    OP_DIV_LONG,
    OP_DIV_UPPER,
    OP_DIV_LOWER,
    OP_MUL_LONG,
    OP_MUL_LOWER,
    OP_MUL_UPPER,
    OP_ARM,
    OP_SPAN
  } tsr_op_t;

  typedef struct packed {
    tsr_op_t op;
  } tsr_cmd_t;

  typedef struct packed {
    logic drop;
    logic upper_nz;
    logic lower_nz;
    logic div_done;
  } tsr_stat_t;

endpackage

### hdl/tsr_div.sv
// ----------------------------------------------------------------------------
// tsr_div
// Restoring divider for 16.16 edge slopes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsr_div import tsr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [COORD_W:0] numer,
  input  logic [COORD_W-1:0]      denom,
  output logic                    done,
  output logic [FIX_W-1:0]        quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [COORD_W-1:0]   rem;
  logic [COORD_W-1:0]   divisor;
  logic [DIV_W-1:0]     acc;
  logic                 neg;
  logic [COORD_W:0]     numer_abs;
  logic [COORD_W:0]     trial;
  logic [COORD_W:0]     diff;
  logic                 fits;

  always_comb begin
    numer_abs = numer[COORD_W] ? -numer : numer;
    trial     = {rem, acc[DIV_W-1]};
    diff      = trial - {1'b0, divisor};
    fits      = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (count == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  // quotient bits shift into the low end as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      acc     <= {numer_abs[COORD_W-1:0], {FRAC_W{1'b0}}};
      rem     <= '0;
      divisor <= denom;
      neg     <= numer[COORD_W];
      count   <= DIV_CNT_W'(DIV_W - 1);
    end else if (busy) begin
      acc   <= {acc[DIV_W-2:0], fits};
      rem   <= fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      count <= count - 1'b1;
    end
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  assign quotient = neg ? -FIX_W'(acc) : FIX_W'(acc);

endmodule

### hdl/tsr_ctrl.sv
// ----------------------------------------------------------------------------
// tsr_ctrl
// Sequencer for triangle setup and the request/response handshakes.
// ----------------------------------------------------------------------------
module tsr_ctrl import tsr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_type,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  input  tsr_stat_t stat,
  output tsr_cmd_t  cmd
);

  tsr_state_t state;
  tsr_state_t state_next;
  logic       rsp_free;
  logic       take;

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE) && rsp_free;
  assign take      = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take && (req_type == REQ_STEP)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && (req_type == REQ_LOAD)) state_next = ST_SORT;
      end
      ST_SORT:      state_next = ST_PREP;
      ST_PREP:      state_next = stat.drop ? ST_IDLE : ST_DIV_LONG;
      ST_DIV_LONG:  state_next = ST_WAIT_LONG;
      ST_WAIT_LONG: begin
        if (stat.div_done) state_next = ST_DIV_UPPER;
      end
      ST_DIV_UPPER: state_next = stat.upper_nz ? ST_WAIT_UPPER : ST_DIV_LOWER;
      ST_WAIT_UPPER: begin
        if (stat.div_done) state_next = ST_DIV_LOWER;
      end
      ST_DIV_LOWER: state_next = stat.lower_nz ? ST_WAIT_LOWER : ST_MUL_LONG;
      ST_WAIT_LOWER: begin
        if (stat.div_done) state_next = ST_MUL_LONG;
      end
      ST_MUL_LONG:  state_next = ST_MUL_LOWER;
      ST_MUL_LOWER: state_next = ST_MUL_UPPER;
      ST_MUL_UPPER: state_next = ST_ARM;
      ST_ARM:       state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (take) cmd.op = (req_type == REQ_STEP) ? OP_SPAN : OP_CAPTURE;
      end
      ST_SORT:      cmd.op = OP_SORT;
      ST_PREP:      cmd.op = OP_PREP;
      ST_DIV_LONG:  cmd.op = OP_DIV_LONG;
      // a flat edge keeps the zero slope written during prep
      ST_DIV_UPPER: cmd.op = stat.upper_nz ? OP_DIV_UPPER : OP_NONE;
      ST_DIV_LOWER: cmd.op = stat.lower_nz ? OP_DIV_LOWER : OP_NONE;
      ST_MUL_LONG:  cmd.op = OP_MUL_LONG;
      ST_MUL_LOWER: cmd.op = OP_MUL_LOWER;
      ST_MUL_UPPER: cmd.op = OP_MUL_UPPER;
      ST_ARM:       cmd.op = OP_ARM;
      default:      cmd.op = OP_NONE;
    endcase
  end

endmodule

### hdl/tsr_dp.sv
// ----------------------------------------------------------------------------
// tsr_dp
// Datapath: vertex sort, slope setup, edge accumulators and span output.
// ----------------------------------------------------------------------------
module tsr_dp import tsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  tsr_cmd_t          cmd,
  output tsr_stat_t         stat,
  input  tsr_in_t           req,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_data,
  output tsr_out_t          rsp
);

  localparam int EXT_W  = COORD_W + 1;
  localparam int SPAN_W = FIX_W - FRAC_W;
  localparam int CNT_W  = SPAN_W + 2;
  localparam logic signed [EXT_W-1:0]  WIDTH_S   = EXT_W'(SCREEN_WIDTH);
  localparam logic signed [EXT_W-1:0]  HEIGHT_S  = EXT_W'(SCREEN_HEIGHT);
  localparam logic signed [EXT_W-1:0]  ROW_MAX_S = EXT_W'(SCREEN_HEIGHT - 1);
  localparam logic signed [SPAN_W-1:0] COL_MAX_S = SPAN_W'(SCREEN_WIDTH - 1);

  function automatic logic [FIX_W-1:0] to_fixed(input logic signed [COORD_W-1:0] v);
    return {{(FIX_W - FRAC_W - COORD_W){v[COORD_W-1]}}, v, {FRAC_W{1'b0}}};
  endfunction

  // configuration and walk state
  logic [ADDR_W-1:0]         frame_base;
  logic                      walking;
  logic [ROW_W-1:0]          current_row;
  logic [ROW_W-1:0]          final_row;
  logic signed [COORD_W-1:0] middle_y;
  logic [FIX_W-1:0]          long_edge_pos;
  logic [FIX_W-1:0]          short_edge_pos;
  logic [FIX_W-1:0]          long_edge_step;
  logic [FIX_W-1:0]          upper_edge_step;
  logic [FIX_W-1:0]          lower_edge_step;
  logic [FIX_W-1:0]          lower_edge_start;
  logic [COLOR_W-1:0]        held_color;

  // setup registers
  logic signed [COORD_W-1:0] cap_x [3];
  logic signed [COORD_W-1:0] cap_y [3];
  logic [COLOR_W-1:0]        cap_color;
  logic signed [COORD_W-1:0] sx [3];
  logic signed [COORD_W-1:0] sy [3];
  logic                      cull;
  logic signed [COORD_W-1:0] first_y;
  logic [ROW_W-1:0]          fin_row;
  logic [FIX_W-1:0]          prod;
  tsr_op_t                   div_op;

  // sort and cull
  logic signed [COORD_W-1:0] mnx, mxx, mny, mxy, tmp;
  logic signed [COORD_W-1:0] tx [3];
  logic signed [COORD_W-1:0] ty [3];
  logic                      cull_next;

  // prep
  logic signed [COORD_W-1:0] first_c;
  logic signed [EXT_W-1:0]   fin_src;
  logic signed [EXT_W-1:0]   fin_c;

  // divider and multiplier
  logic                      div_start;
  logic                      div_done;
  logic signed [EXT_W-1:0]   div_num;
  logic signed [EXT_W-1:0]   div_den;
  logic [FIX_W-1:0]          div_q;
  logic signed [EXT_W-1:0]   long_rows;
  logic signed [EXT_W-1:0]   lower_rows;
  logic [FIX_W-1:0]          mul_a;
  logic [COORD_W-1:0]        mul_b;
  logic [FIX_W-1:0]          prod_next;

  // span
  logic signed [SPAN_W-1:0]  pos_a, pos_b, lo, hi, lo_c, hi_c;
  logic signed [CNT_W-1:0]   cnt;
  logic                      span_ok;
  logic [ADDR_W-1:0]         pix;
  logic                      at_final;
  logic [ROW_W:0]            row_inc;
  logic                      row_hits_mid;
  logic                      row_upper;
  tsr_out_t                  span;

  always_comb begin
    mnx = cap_x[0];
    mxx = cap_x[0];
    mny = cap_y[0];
    mxy = cap_y[0];
    tmp = '0;
    for (int i = 1; i < 3; i++) begin
      if (cap_x[i] < mnx) mnx = cap_x[i];
      if (cap_x[i] > mxx) mxx = cap_x[i];
      if (cap_y[i] < mny) mny = cap_y[i];
      if (cap_y[i] > mxy) mxy = cap_y[i];
    end
    cull_next = mxx[COORD_W-1] || (EXT_W'(mnx) >= WIDTH_S) ||
                mxy[COORD_W-1] || (EXT_W'(mny) >= HEIGHT_S);

    // three strict compare-swaps on y
    tx = cap_x;
    ty = cap_y;
    if (ty[0] > ty[1]) begin
      tmp = tx[0]; tx[0] = tx[1]; tx[1] = tmp;
      tmp = ty[0]; ty[0] = ty[1]; ty[1] = tmp;
    end
    if (ty[0] > ty[2]) begin
      tmp = tx[0]; tx[0] = tx[2]; tx[2] = tmp;
      tmp = ty[0]; ty[0] = ty[2]; ty[2] = tmp;
    end
    if (ty[1] > ty[2]) begin
      tmp = tx[1]; tx[1] = tx[2]; tx[2] = tmp;
      tmp = ty[1]; ty[1] = ty[2]; ty[2] = tmp;
    end
  end

  always_comb begin
    first_c = sy[0][COORD_W-1] ? '0 : sy[0];
    fin_src = (sy[2] > sy[1]) ? EXT_W'(sy[2]) : EXT_W'(sy[1]) - EXT_W'(1);
    fin_c   = (fin_src > ROW_MAX_S) ? ROW_MAX_S : fin_src;
  end

  assign stat.drop     = cull || (sy[2] == sy[0]) || (fin_c < EXT_W'(first_c));
  assign stat.upper_nz = sy[1] > sy[0];
  assign stat.lower_nz = sy[2] > sy[1];
  assign stat.div_done = div_done;

  always_comb begin
    div_start = cmd.op inside {OP_DIV_LONG, OP_DIV_UPPER, OP_DIV_LOWER};
    case (cmd.op)
      OP_DIV_UPPER: begin
        div_num = EXT_W'(sx[1]) - EXT_W'(sx[0]);
        div_den = EXT_W'(sy[1]) - EXT_W'(sy[0]);
      end
      OP_DIV_LOWER: begin
        div_num = EXT_W'(sx[2]) - EXT_W'(sx[1]);
        div_den = EXT_W'(sy[2]) - EXT_W'(sy[1]);
      end
      default: begin
        div_num = EXT_W'(sx[2]) - EXT_W'(sx[0]);
        div_den = EXT_W'(sy[2]) - EXT_W'(sy[0]);
      end
    endcase
  end

  tsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (div_num),
    .denom    (div_den[COORD_W-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  // rows skipped above the screen edge on each edge
  always_comb begin
    long_rows  = EXT_W'(first_y) - EXT_W'(sy[0]);
    lower_rows = sy[1][COORD_W-1] ? -EXT_W'(sy[1]) : '0;
    case (cmd.op)
      OP_MUL_LONG: begin
        mul_a = long_edge_step;
        mul_b = long_rows[COORD_W-1:0];
      end
      OP_MUL_LOWER: begin
        mul_a = lower_edge_step;
        mul_b = lower_rows[COORD_W-1:0];
      end
      default: begin
        mul_a = upper_edge_step;
        mul_b = long_rows[COORD_W-1:0];
      end
    endcase
    prod_next = FIX_W'(mul_a * mul_b);
  end

  always_comb begin
    pos_a   = long_edge_pos[FIX_W-1:FRAC_W];
    pos_b   = short_edge_pos[FIX_W-1:FRAC_W];
    lo      = (pos_a > pos_b) ? pos_b : pos_a;
    hi      = (pos_a > pos_b) ? pos_a : pos_b;
    lo_c    = lo[SPAN_W-1] ? '0 : lo;
    hi_c    = (hi > COL_MAX_S) ? COL_MAX_S : hi;
    cnt     = CNT_W'(hi_c) - CNT_W'(lo_c) + CNT_W'(1);
    span_ok = cnt > 0;
    pix     = ADDR_W'(current_row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(lo_c[COL_W-1:0]);

    at_final     = current_row == final_row;
    row_inc      = {1'b0, current_row} + 1'b1;
    row_hits_mid = $signed({{(EXT_W - ROW_W - 1){1'b0}}, row_inc}) == EXT_W'(middle_y);
    row_upper    = $signed({{(EXT_W - ROW_W){1'b0}}, current_row}) < EXT_W'(middle_y);

    span = '0;
    if (!walking) begin
      span.last = 1'b1;
    end else begin
      span.row        = current_row;
      span.span_color = held_color;
      span.last       = at_final;
      if (span_ok) begin
        span.span_valid    = 1'b1;
        span.left_x        = lo_c[COL_W-1:0];
        span.right_x       = hi_c[COL_W-1:0];
        span.pixel_count   = cnt[COL_W-1:0];
        span.start_address = frame_base + {pix[ADDR_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= '0;
      walking    <= 1'b0;
    end else begin
      if (cfg_we) frame_base <= cfg_data;
      case (cmd.op)
        OP_CAPTURE: walking <= 1'b0;
        OP_ARM:     walking <= 1'b1;
        OP_SPAN: begin
          if (at_final) walking <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        cap_x[0]  <= req.vert_a_x;
        cap_y[0]  <= req.vert_a_y;
        cap_x[1]  <= req.vert_b_x;
        cap_y[1]  <= req.vert_b_y;
        cap_x[2]  <= req.vert_c_x;
        cap_y[2]  <= req.vert_c_y;
        cap_color <= req.fill_color;
      end
      OP_SORT: begin
        sx   <= tx;
        sy   <= ty;
        cull <= cull_next;
      end
      OP_PREP: begin
        first_y         <= first_c;
        fin_row         <= fin_c[ROW_W-1:0];
        upper_edge_step <= '0;
        lower_edge_step <= '0;
      end
      OP_MUL_LONG: begin
        prod <= prod_next;
      end
      OP_MUL_LOWER: begin
        long_edge_pos <= to_fixed(sx[0]) + prod;
        prod          <= prod_next;
      end
      OP_MUL_UPPER: begin
        lower_edge_start <= to_fixed(sx[1]) + prod;
        prod             <= prod_next;
      end
      OP_ARM: begin
        short_edge_pos <= (first_y < sy[1]) ? to_fixed(sx[0]) + prod : lower_edge_start;
        middle_y       <= sy[1];
        current_row    <= first_y[ROW_W-1:0];
        final_row      <= fin_row;
        held_color     <= cap_color;
      end
      OP_SPAN: begin
        rsp <= span;
        if (walking && !at_final) begin
          long_edge_pos <= long_edge_pos + long_edge_step;
          if (row_hits_mid) begin
            short_edge_pos <= lower_edge_start;
          end else if (row_upper) begin
            short_edge_pos <= short_edge_pos + upper_edge_step;
          end else begin
            short_edge_pos <= short_edge_pos + lower_edge_step;
          end
          current_row <= row_inc[ROW_W-1:0];
        end
      end
      default: ;
    endcase

    if (div_start) div_op <= cmd.op;
    if (div_done) begin
      case (div_op)
        OP_DIV_UPPER: upper_edge_step <= div_q;
        OP_DIV_LOWER: lower_edge_step <= div_q;
        default:      long_edge_step  <= div_q;
      endcase
    end
  end

endmodule

### hdl/triangle_scanline_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_scanline_rasterizer
// Scanline edge-walking triangle rasterizer: triangle setup and per-row spans.
// ----------------------------------------------------------------------------
//
//   channel   handshake                 payload    transaction
//   -------   -----------------------   --------   ------------------------------
//   request   req_valid / req_ready     req        load triangle or step one row
//   response  rsp_valid / rsp_ready     rsp        one span per step request
//   config    cfg_we                    cfg_data   frame base byte address
//
// A step request puts its span in an output register, and the next request is
// taken in the same cycle the span is taken.
// A load ends after sort and prep when the triangle is dropped; otherwise it
// runs the shared 28-step slope divider once per edge that is not flat.
// No request is taken during a load or while an untaken span blocks the output.
// Synchronous reset clears the walk, the frame base and the response valid.
module triangle_scanline_rasterizer import tsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  tsr_in_t           req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output tsr_out_t          rsp,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_data
);

  tsr_cmd_t  dp_cmd;
  tsr_stat_t dp_stat;

  tsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  tsr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rsp      (rsp)
  );

`ifndef ASSERT_OFF
  // the divider only finishes while setup holds the request side closed
  assert property (@(posedge clk) disable iff (rst) dp_stat.div_done |-> !req_ready)
    else $error("divider finished while requests were open");

  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req.req_type == REQ_STEP)) |=> rsp_valid)
    else $error("step transaction produced no span");

  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req.req_type == REQ_LOAD)) |=> !rsp_valid)
    else $error("load transaction produced a span");

  assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.op == OP_CAPTURE) |=> (dp_cmd.op == OP_SORT))
    else $error("captured triangle was not sorted");
`endif

endmodule
